@@ rtl/pett_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pett_pkg
// Shared types and codes for the periodic event trigger table.
// ----------------------------------------------------------------------------
package pett_pkg;

    localparam int TIME_W     = 32;
    localparam int CODE_W     = 8;
    localparam int ID_W       = 7;
    localparam int IVAL_W     = 16;
    localparam int POS_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int RESULT_CAP = 32;
    localparam int FIRE_W     = $clog2(RESULT_CAP + 1);
    localparam int STEP_W     = $clog2(TIME_W);

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_EVENT_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_MARKER = 1'd1;

    typedef struct packed {
        logic [TIME_W-1:0]        start_time;
        logic [TIME_W-1:0]        end_time;
        logic signed [CODE_W-1:0] event_code;
        logic [IVAL_W-1:0]        repeat_interval;
        logic signed [POS_W-1:0]  place_x;
        logic signed [POS_W-1:0]  place_y;
    } entry_t;

    typedef struct packed {
        logic [ID_W-1:0]         code;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } fire_t;

    typedef struct packed {
        logic  valid;
        fire_t fire;
        logic  last;
    } push_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } mod_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_EMIT,
        ST_FLUSH
    } seq_state_t;

endpackage
`default_nettype wire

@@ rtl/pett_entry_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pett_entry_mem
// Entry table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pett_entry_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [ADDR_W-1:0]     waddr,
    input  wire pett_pkg::entry_t      wdata,
    input  wire logic                  re,
    input  wire logic [ADDR_W-1:0]     raddr,
    output pett_pkg::entry_t           rdata
);
    import pett_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/pett_mod_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pett_mod_unit
// Restoring remainder unit: 32-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module pett_mod_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pett_pkg::TIME_W-1:0]   dividend,
    input  wire logic [pett_pkg::IVAL_W-1:0]   divisor,
    output pett_pkg::mod_status_t              status
);
    import pett_pkg::*;

    logic [TIME_W-1:0] dvd_reg;
    logic [IVAL_W-1:0] div_reg;
    logic [IVAL_W-1:0] rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [IVAL_W:0]   trial;
    logic [IVAL_W:0]   diff;
    logic [IVAL_W-1:0] rem_step;

    // The partial remainder stays below the divisor, so it fits the divisor width.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[TIME_W-1]};
        diff     = trial - {1'b0, div_reg};
        rem_step = (trial >= {1'b0, div_reg}) ? diff[IVAL_W-1:0] : trial[IVAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(TIME_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule
`default_nettype wire

@@ rtl/pett_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pett_ctrl
// Sequencer: table loads, frame timer, and the per-tick walk over the entries.
// ----------------------------------------------------------------------------
module pett_ctrl #(
    parameter int MAX_ENTRIES = 32,
    parameter int IDX_W       = 5,
    parameter int CNT_W       = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [1:0]                    action,
    input  wire logic [pett_pkg::ID_W-1:0]     event_limit,
    input  wire logic                          out_space,
    output pett_pkg::push_t                    push,
    output logic                               mem_we,
    output logic [IDX_W-1:0]                   mem_waddr,
    output logic                               mem_re,
    output logic [IDX_W-1:0]                   mem_raddr,
    input  wire pett_pkg::entry_t              mem_rdata,
    output logic                               mod_start,
    output logic [pett_pkg::TIME_W-1:0]        mod_dividend,
    output logic [pett_pkg::IVAL_W-1:0]        mod_divisor,
    input  wire pett_pkg::mod_status_t         mod_status
);
    import pett_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] timer_reg, timer_next;
    logic [FIRE_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic              hold_valid_reg, hold_valid_next;
    fire_t             hold_reg, hold_next;
    fire_t             cand_reg, cand_next;

    logic accept;
    logic last_entry;
    logic in_window;
    logic code_ok;
    logic candidate;
    logic can_push;

    always_comb
    begin
        accept     = item_valid && (state_reg == ST_IDLE);
        last_entry = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
        in_window  = (mem_rdata.start_time <= timer_reg) && (mem_rdata.end_time >= timer_reg);
        code_ok    = !mem_rdata.event_code[CODE_W-1] &&
                     (mem_rdata.event_code[ID_W-1:0] < event_limit);
        candidate  = in_window && code_ok && (mem_rdata.repeat_interval != '0) &&
                     (fire_cnt_reg < FIRE_W'(RESULT_CAP));
        can_push   = !hold_valid_reg || out_space;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_TICK) && (count_reg != '0))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (candidate)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = last_entry ? ST_FLUSH : ST_READ;
                end
            end
            ST_DIV:
            begin
                if (mod_status.done)
                begin
                    if (mod_status.rem_zero)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = last_entry ? ST_FLUSH : ST_READ;
                    end
                end
            end
            ST_EMIT:
            begin
                if (can_push)
                begin
                    state_next = last_entry ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH:
            begin
                if (can_push)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath. A firing is held back one step so that the last
    // firing of a tick can be marked when the walk ends.
    always_comb
    begin
        idx_next        = idx_reg;
        count_next      = count_reg;
        timer_next      = timer_reg;
        fire_cnt_next   = fire_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        cand_next       = cand_reg;
        item_stall      = (state_reg != ST_IDLE);
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IDX_W-1:0];
        mem_re          = (state_reg == ST_READ);
        mem_raddr       = idx_reg;
        mod_start       = 1'b0;
        mod_dividend    = timer_reg - mem_rdata.start_time;
        mod_divisor     = mem_rdata.repeat_interval;
        push.valid      = 1'b0;
        push.fire       = hold_reg;
        push.last       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_LOAD:
                        begin
                            if (count_reg < CNT_W'(MAX_ENTRIES))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_TICK:
                        begin
                            idx_next      = '0;
                            fire_cnt_next = '0;
                        end
                        ACT_RESTART:
                        begin
                            count_next = '0;
                            timer_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                mod_start      = candidate;
                cand_next.code = mem_rdata.event_code[ID_W-1:0];
                cand_next.x    = mem_rdata.place_x;
                cand_next.y    = mem_rdata.place_y;
            end
            ST_EMIT:
            begin
                if (can_push)
                begin
                    push.valid      = hold_valid_reg;
                    hold_next       = cand_reg;
                    hold_valid_next = 1'b1;
                    fire_cnt_next   = fire_cnt_reg + FIRE_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (can_push)
                begin
                    push.valid      = hold_valid_reg;
                    push.last       = 1'b1;
                    hold_valid_next = 1'b0;
                    if (timer_reg != '1)
                    begin
                        timer_next = timer_reg + TIME_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase

        if ((state_reg != ST_IDLE) && (state_next == ST_READ))
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            count_reg      <= '0;
            timer_reg      <= '0;
            fire_cnt_reg   <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            timer_reg      <= timer_next;
            fire_cnt_reg   <= fire_cnt_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        cand_reg <= cand_next;
    end

    // The remainder unit only runs while the walk waits on it.
    a_mod_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        mod_status.busy |-> (state_reg == ST_DIV))
        else $error("remainder unit busy outside the divide wait");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> out_space)
        else $error("result pushed while the output register is full");

    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FIRE_W'(RESULT_CAP))
        else $error("firing count passed the per-tick cap");

    a_last_ends_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.last) |=> (state_reg == ST_IDLE) && !hold_valid_reg)
        else $error("walk did not end after the last firing");

    a_idle_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held firing left over at idle");

endmodule
`default_nettype wire

@@ rtl/periodic_event_trigger_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_event_trigger_table
// Timed event table with a frame timer that reports periodic firings.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid / item_stall) takes one transaction per
//   command: load appends an entry unless the table is full, restart empties
//   the table and zeroes the timer, tick walks a non-empty table once and then
//   advances the timer unless it is already at its maximum. A tick is taken,
//   reads then tests each stored entry in turn, and closes with a flush step.
//   An entry that passes the window, code and interval tests while the tick is
//   under its firing cap also waits for the remainder of (timer - start) by the
//   interval, formed one bit per cycle in a single shared unit, and then goes
//   through an emit step when it fires. item_stall stays high for the whole
//   walk.
//   Each firing is a transaction on the result channel (result_valid /
//   result_stall), held in an output register; last_fired marks the final one
//   of the tick. A stalled result holds the walk until the register drains.
//   Reset empties the table, zeroes the timer and loads the register defaults;
//   the entry memory is not cleared, as only loaded entries are ever read.
//   Configuration writes on cfg_we belong in idle periods.
// ----------------------------------------------------------------------------
module periodic_event_trigger_table #(
    parameter int MAX_ENTRIES = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire logic [1:0]                         action,
    input  wire logic [pett_pkg::TIME_W-1:0]        start_time,
    input  wire logic [pett_pkg::TIME_W-1:0]        end_time,
    input  wire logic signed [pett_pkg::CODE_W-1:0] event_code,
    input  wire logic [pett_pkg::IVAL_W-1:0]        repeat_interval,
    input  wire logic signed [pett_pkg::POS_W-1:0]  place_x,
    input  wire logic signed [pett_pkg::POS_W-1:0]  place_y,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic [pett_pkg::ID_W-1:0]               fired_code,
    output logic signed [pett_pkg::POS_W-1:0]       fired_x,
    output logic signed [pett_pkg::POS_W-1:0]       fired_y,
    output logic                                    random_x,
    output logic                                    random_y,
    output logic                                    last_fired,
    input  wire logic                               cfg_we,
    input  wire logic [pett_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pett_pkg::CFG_W-1:0]         cfg_data
);
    import pett_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [ID_W-1:0]         limit_reg;
    logic signed [POS_W-1:0] marker_reg;

    logic                    out_valid_reg;
    fire_t                   out_fire_reg;
    logic                    out_rand_x_reg;
    logic                    out_rand_y_reg;
    logic                    out_last_reg;
    logic                    out_space;

    entry_t                  item_entry;
    push_t                   push;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic                    mem_re;
    logic [IDX_W-1:0]        mem_raddr;
    entry_t                  mem_rdata;
    logic                    mod_start;
    logic [TIME_W-1:0]       mod_dividend;
    logic [IVAL_W-1:0]       mod_divisor;
    mod_status_t             mod_status;

    assign item_entry.start_time      = start_time;
    assign item_entry.end_time        = end_time;
    assign item_entry.event_code      = event_code;
    assign item_entry.repeat_interval = repeat_interval;
    assign item_entry.place_x         = place_x;
    assign item_entry.place_y         = place_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= ID_W'(13);
            marker_reg <= -16'sd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EVENT_LIMIT:   limit_reg  <= cfg_data[ID_W-1:0];
                REG_RANDOM_MARKER: marker_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign out_space = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            out_fire_reg   <= push.fire;
            out_last_reg   <= push.last;
            out_rand_x_reg <= (push.fire.x == marker_reg);
            out_rand_y_reg <= (push.fire.y == marker_reg);
        end
    end

    assign result_valid = out_valid_reg;
    assign fired_code   = out_fire_reg.code;
    assign fired_x      = out_fire_reg.x;
    assign fired_y      = out_fire_reg.y;
    assign random_x     = out_rand_x_reg;
    assign random_y     = out_rand_y_reg;
    assign last_fired   = out_last_reg;

    pett_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .event_limit  (limit_reg),
        .out_space    (out_space),
        .push         (push),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .mod_start    (mod_start),
        .mod_dividend (mod_dividend),
        .mod_divisor  (mod_divisor),
        .mod_status   (mod_status)
    );

    // Writes happen only at idle and reads only during a walk, so the two
    // ports never touch the same entry in one cycle.
    pett_entry_mem #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_entry_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (item_entry),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pett_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .status   (mod_status)
    );

endmodule
`default_nettype wire

@@ tb/periodic_event_trigger_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_event_trigger_table_tb
// Self-checking bench for the timed event table: loads, ticks and restarts go
// in through the item channel. A predictor of the table and frame timer works
// out each tick's firings, and the results are checked in order, field by
// field, under random idling on both channels and several register settings.
// ----------------------------------------------------------------------------
module periodic_event_trigger_table_tb;

    import pett_pkg::*;

    localparam int         ENTRY_SLOTS    = 32;
    localparam int         RESET_CYCLES   = 9;
    localparam int         RANDOM_PHASES  = 8;
    localparam int         PHASE_ITEMS    = 28;
    localparam int         DRAIN_CYCLES   = 1500;
    localparam int         LONG_HOLD      = 2000;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         REPORT_LIMIT   = 10;
    localparam logic [1:0] ACT_UNUSED     = 2'd3;

    typedef struct {
        logic [1:0] action;
        entry_t     ent;
    } command_t;

    typedef struct {
        logic [ID_W-1:0]         code;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    flag_x;
        logic                    flag_y;
        logic                    last;
    } firing_t;

    logic                       clk             = 1'b0;
    logic                       rst_n           = 1'b0;
    logic                       item_valid      = 1'b0;
    logic                       item_stall;
    logic [1:0]                 action          = ACT_LOAD;
    logic [TIME_W-1:0]          start_time      = '0;
    logic [TIME_W-1:0]          end_time        = '0;
    logic signed [CODE_W-1:0]   event_code      = '0;
    logic [IVAL_W-1:0]          repeat_interval = '0;
    logic signed [POS_W-1:0]    place_x         = '0;
    logic signed [POS_W-1:0]    place_y         = '0;
    logic                       result_valid;
    logic                       result_stall    = 1'b0;
    logic [ID_W-1:0]            fired_code;
    logic signed [POS_W-1:0]    fired_x;
    logic signed [POS_W-1:0]    fired_y;
    logic                       random_x;
    logic                       random_y;
    logic                       last_fired;
    logic                       cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index       = '0;
    logic [CFG_W-1:0]           cfg_data        = '0;

    // Predicted state of the block.
    entry_t                     slots [ENTRY_SLOTS];
    int                         stored          = 0;
    logic [TIME_W-1:0]          frame_clock     = '0;
    logic [ID_W-1:0]            code_ceiling    = 7'd13;
    logic signed [POS_W-1:0]    marker_value    = -16'sd1;

    command_t                   queued_commands [$];
    firing_t                    pending_firings [$];
    command_t                   offered;
    logic                       offering        = 1'b0;
    int                         send_gap        = 0;
    int                         stall_gap       = 0;
    int                         hold_left       = 0;
    int                         hold_ticket     = 0;
    int                         hold_served     = 0;
    logic                       calm            = 1'b0;
    int                         mismatches      = 0;
    int                         quiet_cycles    = 0;

    periodic_event_trigger_table #(.MAX_ENTRIES(ENTRY_SLOTS)) u_dut (.*);

    always #2 clk = ~clk;

    task automatic queue_command(input command_t c);
        queued_commands = {queued_commands, c};
    endtask

    // Applies one accepted transaction to the predicted table and queues the
    // firings that a tick produces.
    task automatic advance_table(input command_t cmd);
        firing_t batch [RESULT_CAP];
        entry_t  e;
        int      n;
        int      i;
        n = 0;
        case (cmd.action)
            ACT_LOAD:
            begin
                if (stored < ENTRY_SLOTS)
                begin
                    slots[stored] = cmd.ent;
                    stored++;
                end
            end
            ACT_RESTART:
            begin
                stored = 0;
                frame_clock = '0;
            end
            ACT_TICK:
            begin
                if (stored != 0)
                begin
                    for (i = 0; i < stored; i++)
                    begin
                        e = slots[i];
                        if (e.start_time <= frame_clock && e.end_time >= frame_clock
                            && e.repeat_interval != 0 && n < RESULT_CAP)
                        begin
                            if ((frame_clock - e.start_time) % e.repeat_interval == 0
                                && !e.event_code[CODE_W-1]
                                && e.event_code[ID_W-1:0] < code_ceiling)
                            begin
                                batch[n] = '{code: e.event_code[ID_W-1:0], x: e.place_x,
                                             y: e.place_y,
                                             flag_x: (e.place_x == marker_value),
                                             flag_y: (e.place_y == marker_value),
                                             last: 1'b0};
                                n++;
                            end
                        end
                    end
                    if (n > 0)
                        batch[n-1].last = 1'b1;
                    for (i = 0; i < n; i++)
                        pending_firings = {pending_firings, batch[i]};
                    if (frame_clock != '1)
                        frame_clock++;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic command_t random_fields(input logic [1:0] act);
        command_t c;
        c.action               = act;
        c.ent.start_time       = $urandom;
        c.ent.end_time         = $urandom;
        c.ent.event_code       = $urandom;
        c.ent.repeat_interval  = $urandom;
        c.ent.place_x          = $urandom;
        c.ent.place_y          = $urandom;
        return c;
    endfunction

    // A load whose window, interval and code are mostly chosen to fire soon.
    function automatic command_t make_load();
        command_t c;
        c = random_fields(ACT_LOAD);
        if ($urandom_range(0, 7) != 0)
            c.ent.start_time = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
            0: c.ent.end_time = '1;
            1: ;
            default: c.ent.end_time = c.ent.start_time + $urandom_range(0, 40);
        endcase
        case ($urandom_range(0, 9))
            0: c.ent.repeat_interval = '0;
            1: ;
            default: c.ent.repeat_interval = $urandom_range(1, 4);
        endcase
        if ($urandom_range(0, 5) != 0)
            c.ent.event_code = (code_ceiling == 0) ? 0 : $urandom_range(0, code_ceiling - 1);
        if ($urandom_range(0, 3) == 0)
            c.ent.place_x = marker_value;
        if ($urandom_range(0, 3) == 0)
            c.ent.place_y = marker_value;
        return c;
    endfunction

    function automatic command_t load_cmd(input logic [TIME_W-1:0] first,
                                          input logic [TIME_W-1:0] final_frame,
                                          input logic signed [CODE_W-1:0] code,
                                          input logic [IVAL_W-1:0] ival,
                                          input logic signed [POS_W-1:0] x,
                                          input logic signed [POS_W-1:0] y);
        command_t c;
        c.action = ACT_LOAD;
        c.ent    = '{first, final_frame, code, ival, x, y};
        return c;
    endfunction

    // Waits until the block has nothing left to do, including a tick that is
    // still walking entries after its last result.
    task automatic settle();
        do
            @(negedge clk);
        while (queued_commands.size() != 0 || offering || pending_firings.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_EVENT_LIMIT)
            code_ceiling = data[ID_W-1:0];
        else
            marker_value = data;
    endtask

    // Item driver.
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && !item_stall)
            begin
                advance_table(offered);
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (queued_commands.size() != 0)
                begin
                    offered  = queued_commands.pop_front();
                    offering = 1'b1;
                    action          <= offered.action;
                    start_time      <= offered.ent.start_time;
                    end_time        <= offered.ent.end_time;
                    event_code      <= offered.ent.event_code;
                    repeat_interval <= offered.ent.repeat_interval;
                    place_x         <= offered.ent.place_x;
                    place_y         <= offered.ent.place_y;
                    if (!calm && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 16);
                end
            end
            item_valid <= offering;
        end
    end

    // Result monitor and receiver stall.
    always @(posedge clk)
    begin
        firing_t want;
        logic    stall_next;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_firings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result code %0d x %0d y %0d",
                                 $time, fired_code, fired_x, fired_y);
                end
                else
                begin
                    want = pending_firings.pop_front();
                    if (fired_code !== want.code || fired_x !== want.x || fired_y !== want.y
                        || random_x !== want.flag_x || random_y !== want.flag_y
                        || last_fired !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: result mismatch (expected/actual) code %0d/%0d ",
                                      "x %0d/%0d y %0d/%0d rx %0b/%0b ry %0b/%0b last %0b/%0b"},
                                     $time, want.code, fired_code, want.x, fired_x,
                                     want.y, fired_y, want.flag_x, random_x,
                                     want.flag_y, random_y, want.last, last_fired);
                    end
                end
            end
            if (hold_ticket != hold_served)
            begin
                hold_served = hold_ticket;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (stall_gap > 0)
            begin
                stall_gap--;
                stall_next = 1'b1;
            end
            else
            begin
                stall_next = 1'b0;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_gap = $urandom_range(1, 16);
            end
            result_stall <= stall_next;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int                      phase;
        int                      added;
        int                      loads;
        int                      ticks;
        command_t                c;
        logic [ID_W-1:0]         lim;
        logic signed [POS_W-1:0] mark;
        logic [CFG_W-ID_W-1:0]   pad;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset settings: limit 13, marker -1.
        queue_command(load_cmd(0, '1, 5, 1, -16'sd1, 16'sd32767));
        queue_command(load_cmd(2, 6, 12, 2, -16'sd32768, -16'sd1));
        queue_command(load_cmd(0, 10, 13, 1, 16'sd7, 16'sd8));
        queue_command(load_cmd(0, 10, -8'sd128, 1, 16'sd9, 16'sd10));
        queue_command(load_cmd(0, '1, 3, 0, 16'sd11, 16'sd12));
        queue_command(load_cmd(0, 0, 0, 16'hFFFF, 16'sd0, 16'sd0));
        queue_command(load_cmd('1, '1, 127, 1, 16'sd1, -16'sd2));
        queue_command(random_fields(ACT_UNUSED));
        repeat (8) queue_command(random_fields(ACT_TICK));
        queue_command(random_fields(ACT_RESTART));
        // A tick on an empty table leaves the timer where it is.
        queue_command(random_fields(ACT_TICK));
        queue_command(load_cmd(0, '1, 5, 1, -16'sd1, 16'sd32767));
        queue_command(random_fields(ACT_TICK));
        settle();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       begin lim = 127; mark = -16'sd32768; end
                1:       begin lim = 0;   mark = 16'sd32767;  end
                2:       begin lim = 64;  mark = 16'sd0;      end
                3:       begin lim = 1;   mark = $urandom;    end
                4:       begin lim = $urandom_range(2, 126); mark = -16'sd1; end
                5:       begin lim = 126; mark = 16'sd1;      end
                6:       begin lim = 13;  mark = $urandom;    end
                default: begin lim = 127; mark = -16'sd32768; end
            endcase
            pad = $urandom;
            write_reg(REG_EVENT_LIMIT, {pad, lim});
            write_reg(REG_RANDOM_MARKER, mark);
            @(negedge clk);
            calm = (phase == RANDOM_PHASES - 1);
            // Hold the result side long enough for the walk and the input to back up.
            if (phase == 2)
                hold_ticket++;
            added = 0;
            while (added < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    c = random_fields($urandom_range(0, 3));
                    queue_command(c);
                    if (c.action != ACT_UNUSED)
                        added++;
                end
                else
                begin
                    if ($urandom_range(0, 3) != 0)
                    begin
                        queue_command(random_fields(ACT_RESTART));
                        added++;
                    end
                    loads = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34)
                                                        : $urandom_range(1, 6);
                    repeat (loads) queue_command(make_load());
                    ticks = $urandom_range(1, 6);
                    repeat (ticks) queue_command(random_fields(ACT_TICK));
                    added += loads + ticks;
                end
            end
            settle();
        end

        if (mismatches == 0 && pending_firings.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pett_pkg.sv
rtl/pett_entry_mem.sv
rtl/pett_mod_unit.sv
rtl/pett_ctrl.sv
rtl/periodic_event_trigger_table.sv
tb/periodic_event_trigger_table_tb.sv
